@@ hw/rtl/scf_pkg.sv @@
package scf_pkg;

    // Frame layout, by byte position.
    localparam logic [4:0] POS_SPEED_L_LO  = 5'd0;
    localparam logic [4:0] POS_SPEED_L_HI  = 5'd1;
    localparam logic [4:0] POS_BATTERY     = 5'd2;
    localparam logic [4:0] POS_IR_LEFT     = 5'd3;
    localparam logic [4:0] POS_IR_LEFT_2   = 5'd4;
    localparam logic [4:0] POS_ODO_LEFT    = 5'd5;
    localparam logic [4:0] POS_SPEED_R_LO  = 5'd9;
    localparam logic [4:0] POS_SPEED_R_HI  = 5'd10;
    localparam logic [4:0] POS_IR_RIGHT    = 5'd11;
    localparam logic [4:0] POS_IR_RIGHT_2  = 5'd12;
    localparam logic [4:0] POS_ODO_RIGHT   = 5'd13;
    localparam logic [4:0] CRC_LEN         = 5'd18;
    localparam logic [4:0] POS_CRC_LO      = 5'd19;
    localparam logic [4:0] LAST_POS        = 5'd20;
    localparam logic [4:0] IDLE_POS        = 5'd21;

    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // floor(n * 52429 / 2^18) equals floor(n / 5) for every 16-bit n.
    localparam logic [16:0] DIV5_RECIP = 17'd52429;
    localparam int          DIV5_SHIFT = 18;

    localparam int SPEED_W = 14;

    typedef struct packed {
        logic       last;       // transfer carries the final byte of a frame
        logic       crc_en;     // transfer carries a byte covered by the CRC
        logic       restart;    // transfer opens a new frame
        logic       at_last;    // next in-frame byte is the final one
        logic       idle;       // waiting for a frame start
    } cap_status_t;

    typedef struct packed {
        logic [7:0]         battery_level;
        logic [SPEED_W-1:0] speed_left;
        logic [SPEED_W-1:0] speed_right;
        logic [7:0]         ir_left;
        logic [7:0]         ir_right;
        logic [7:0]         ir_left_second;
        logic [7:0]         ir_right_second;
        logic [31:0]        odometer_left;
        logic [31:0]        odometer_right;
        logic [7:0]         crc_lo;
    } frame_fields_t;

    // Reflected CRC-16 update by one byte, no final xor.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // Signed 16-bit value divided by five, truncated toward zero.
    function automatic logic [SPEED_W-1:0] div5(input logic [15:0] raw);
        logic [15:0] mag;
        logic [32:0] prod;
        logic [14:0] q;
        logic [14:0] q_signed;
        mag      = raw[15] ? (~raw + 16'd1) : raw;
        prod     = {1'b0, mag} * {16'h0000, DIV5_RECIP};
        q        = prod[32:DIV5_SHIFT];
        q_signed = raw[15] ? (~q + 15'd1) : q;
        return q_signed[SPEED_W-1:0];
    endfunction

endpackage

@@ hw/rtl/scf_crc16.sv @@
module scf_crc16 import scf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  cap_status_t status,
    input  logic [7:0]  data_byte,
    output logic [15:0] crc
);

    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [15:0] crc_base;

    // A frame start always falls on a covered byte, so restart only selects the seed.
    always_comb begin
        crc_base = status.restart ? CRC_INIT : crc_reg;
        crc_next = status.crc_en ? crc_byte(crc_base, data_byte) : crc_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= CRC_INIT;
        end else begin
            crc_reg <= crc_next;
        end
    end

    assign crc = crc_reg;

endmodule

@@ hw/rtl/scf_frame_capture.sv @@
module scf_frame_capture import scf_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          xfer,
    input  logic [7:0]    data_byte,
    input  logic          frame_begin,
    output cap_status_t   status,
    output frame_fields_t fields
);

    logic [4:0]         pos_reg;
    logic [4:0]         pos_next;
    logic [4:0]         eff_pos;
    logic               in_frame;
    logic               store;
    logic [7:0]         byte_reg [0:19];
    logic [SPEED_W-1:0] speed_l_reg;
    logic [SPEED_W-1:0] speed_r_reg;

    always_comb begin
        eff_pos  = frame_begin ? 5'd0 : pos_reg;
        in_frame = (eff_pos <= LAST_POS);
        store    = xfer && in_frame;
        pos_next = pos_reg;
        if (store) begin
            pos_next = (eff_pos < LAST_POS) ? (eff_pos + 5'd1) : IDLE_POS;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= IDLE_POS;
        end else begin
            pos_reg <= pos_next;
        end
    end

    // The final byte is never stored; it goes straight to the CRC compare.
    always_ff @(posedge aclk) begin
        if (store && eff_pos < LAST_POS) begin
            byte_reg[eff_pos] <= data_byte;
        end
    end

    // Each speed is divided as soon as both of its bytes are held.
    always_ff @(posedge aclk) begin
        if (store && eff_pos == POS_BATTERY) begin
            speed_l_reg <= div5({byte_reg[POS_SPEED_L_HI], byte_reg[POS_SPEED_L_LO]});
        end
        if (store && eff_pos == POS_IR_RIGHT) begin
            speed_r_reg <= div5({byte_reg[POS_SPEED_R_HI], byte_reg[POS_SPEED_R_LO]});
        end
    end

    always_comb begin
        status.last    = store && (eff_pos == LAST_POS);
        status.crc_en  = store && (eff_pos < CRC_LEN);
        status.restart = frame_begin;
        status.at_last = (pos_reg == LAST_POS);
        status.idle    = (pos_reg >= IDLE_POS);

        fields.battery_level   = byte_reg[POS_BATTERY];
        fields.speed_left      = speed_l_reg;
        fields.speed_right     = speed_r_reg;
        fields.ir_left         = byte_reg[POS_IR_LEFT];
        fields.ir_right        = byte_reg[POS_IR_RIGHT];
        fields.ir_left_second  = byte_reg[POS_IR_LEFT_2];
        fields.ir_right_second = byte_reg[POS_IR_RIGHT_2];
        fields.odometer_left   = {byte_reg[POS_ODO_LEFT + 5'd3], byte_reg[POS_ODO_LEFT + 5'd2],
                                  byte_reg[POS_ODO_LEFT + 5'd1], byte_reg[POS_ODO_LEFT]};
        fields.odometer_right  = {byte_reg[POS_ODO_RIGHT + 5'd3], byte_reg[POS_ODO_RIGHT + 5'd2],
                                  byte_reg[POS_ODO_RIGHT + 5'd1], byte_reg[POS_ODO_RIGHT]};
        fields.crc_lo          = byte_reg[POS_CRC_LO];
    end

endmodule

@@ hw/rtl/sensor_frame_crc_decoder.sv @@
// Channel  | Direction | tdata                         | tuser
// s_       | in        | data_byte[7:0]                | frame_begin
// m_       | out       | decoded frame, 136 bits       | -
//
// One byte transfer per cycle is accepted while s_tready is high; a result leaves the
// output register in the cycle after the final byte of a frame (byte 20) is taken.
// The CRC advances one byte a cycle on accepted transfers; each speed is divided on the
// transfer that follows its two bytes (byte 2 for left, byte 11 for right).
// Reset leaves the block idle until a byte with frame_begin set.
// s_tready drops only while a result is stalled and the next byte would finish a frame.
module sensor_frame_crc_decoder import scf_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // data_byte
    input  logic [0:0]   s_tuser,   // frame_begin
    output logic         m_tvalid,
    input  logic         m_tready,
    // crc_ok, battery_level, speed_left, speed_right, ir_left, ir_right,
    // ir_left_second, ir_right_second, odometer_left, odometer_right, zero fill
    output logic [135:0] m_tdata
);

    cap_status_t   status;
    frame_fields_t fields;
    logic [15:0]   crc;
    logic          xfer;
    logic          crc_ok;
    logic [132:0]  result;
    logic          m_valid_reg;
    logic          m_valid_next;
    logic [132:0]  m_data_reg;

    assign s_tready = !(m_valid_reg && !m_tready && status.at_last);
    assign xfer     = s_tvalid && s_tready;

    scf_frame_capture u_capture (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .xfer        (xfer),
        .data_byte   (s_tdata),
        .frame_begin (s_tuser[0]),
        .status      (status),
        .fields      (fields)
    );

    scf_crc16 u_crc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .status    (status),
        .data_byte (s_tdata),
        .crc       (crc)
    );

    // The received CRC is little endian: stored byte 19 low, incoming byte 20 high.
    always_comb begin
        crc_ok = ({s_tdata, fields.crc_lo} == crc);
        if (crc_ok) begin
            result = {fields.odometer_right, fields.odometer_left,
                      fields.ir_right_second, fields.ir_left_second,
                      fields.ir_right, fields.ir_left,
                      fields.speed_right, fields.speed_left,
                      fields.battery_level, 1'b1};
        end else begin
            result = '0;
        end
        m_valid_next = status.last ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (status.last) begin
            m_data_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_data_reg};

`ifndef SYNTH
    // A stalled result must never be overwritten by a new frame.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |-> !status.last)
        else $error("result overwritten while stalled");

    // A failed CRC clears every decoded field.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tdata[0]) |-> (m_tdata[132:1] == '0))
        else $error("fields not cleared on CRC mismatch");

    // After the final byte the parser waits for a new frame start.
    assert property (@(posedge aclk) disable iff (!aresetn)
        status.last |=> status.idle)
        else $error("parser not idle after frame end");

    // A result appears in the cycle after a final byte transfer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        status.last |=> m_valid_reg)
        else $error("result missing after final byte");
`endif

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top import scf_pkg::*;;

    localparam int FRAME_BYTES     = 21;
    localparam int STIM_BYTES      = 950;
    localparam int PHASE1_AT       = 350;
    localparam int PHASE2_AT       = 700;
    localparam int HOLD_AT         = 760;
    localparam int HOLD_CYCLES     = 400;
    localparam int DRAIN_CYCLES    = 40;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int TX_IDLE_EARLY   = 23;
    localparam int RX_IDLE_EARLY   = 52;

    typedef struct {
        logic [7:0] data;
        logic       start;
    } frame_byte_t;

    typedef struct {
        logic               crc_ok;
        logic [7:0]         battery;
        logic [SPEED_W-1:0] speed_l;
        logic [SPEED_W-1:0] speed_r;
        logic [7:0]         ir_l;
        logic [7:0]         ir_r;
        logic [7:0]         ir_l2;
        logic [7:0]         ir_r2;
        logic [31:0]        odo_l;
        logic [31:0]        odo_r;
        logic [2:0]         fill;
    } sensor_result_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata  = 8'h00;   // data_byte
    logic [0:0]   s_tuser  = 1'b0;    // frame_begin
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // crc_ok, battery_level, speed_left, speed_right, ir_left, ir_right,
    // ir_left_second, ir_right_second, odometer_left, odometer_right, zero fill
    logic [135:0] m_tdata;

    frame_byte_t    byte_queue[$];
    sensor_result_t decoded_queue[$];

    // Decoder state as the testbench sees it.
    logic [4:0]  frame_pos = IDLE_POS;
    logic [15:0] crc_acc   = CRC_INIT;
    logic [7:0]  frame_bytes[FRAME_BYTES];

    int bytes_taken = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;
    int cycle_count = 0;
    int mismatches  = 0;
    int good_frames = 0;
    int bad_frames  = 0;
    int tx_idle_pct;
    int rx_idle_pct;

    sensor_frame_crc_decoder uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always_comb begin
        if (bytes_taken < PHASE1_AT) begin
            tx_idle_pct = TX_IDLE_EARLY;
            rx_idle_pct = RX_IDLE_EARLY;
        end else if (bytes_taken < PHASE2_AT) begin
            tx_idle_pct = RX_IDLE_EARLY;
            rx_idle_pct = TX_IDLE_EARLY;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
    end

    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Signed 16-bit speed over five; SystemVerilog division truncates toward zero.
    function automatic logic [SPEED_W-1:0] speed_div5(input logic [7:0] lo, input logic [7:0] hi);
        int v;
        v = int'($signed({hi, lo}));
        v = v / 5;
        return v[SPEED_W-1:0];
    endfunction

    function automatic logic [31:0] odo_word(input logic [4:0] p);
        return {frame_bytes[p + 5'd3], frame_bytes[p + 5'd2],
                frame_bytes[p + 5'd1], frame_bytes[p]};
    endfunction

    task automatic decode_byte(input logic [7:0] b, input logic start);
        sensor_result_t r;
        if (start) begin
            frame_pos = 5'd0;
            crc_acc   = CRC_INIT;
        end
        if (frame_pos > LAST_POS) begin
            return;
        end
        frame_bytes[frame_pos] = b;
        if (frame_pos < CRC_LEN) begin
            crc_acc = crc16_update(crc_acc, b);
        end
        if (frame_pos != LAST_POS) begin
            frame_pos = frame_pos + 5'd1;
            return;
        end
        frame_pos = IDLE_POS;
        r = '{default: '0};
        if ({frame_bytes[LAST_POS], frame_bytes[POS_CRC_LO]} == crc_acc) begin
            r.crc_ok  = 1'b1;
            r.battery = frame_bytes[POS_BATTERY];
            r.speed_l = speed_div5(frame_bytes[POS_SPEED_L_LO], frame_bytes[POS_SPEED_L_HI]);
            r.speed_r = speed_div5(frame_bytes[POS_SPEED_R_LO], frame_bytes[POS_SPEED_R_HI]);
            r.ir_l    = frame_bytes[POS_IR_LEFT];
            r.ir_r    = frame_bytes[POS_IR_RIGHT];
            r.ir_l2   = frame_bytes[POS_IR_LEFT_2];
            r.ir_r2   = frame_bytes[POS_IR_RIGHT_2];
            r.odo_l   = odo_word(POS_ODO_LEFT);
            r.odo_r   = odo_word(POS_ODO_RIGHT);
        end
        decoded_queue.push_back(r);
    endtask

    // Driver: presents queued bytes and feeds every accepted transfer to the decoder model.
    always @(posedge aclk) begin : byte_driver
        frame_byte_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            s_tuser  <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                decode_byte(s_tdata, s_tuser[0]);
                bytes_taken <= bytes_taken + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (byte_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    nxt = byte_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.data;
                    s_tuser  <= nxt.start;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // One long output stall once the traffic runs at full rate.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && bytes_taken >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : result_monitor
        sensor_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (decoded_queue.size() == 0) begin
                $error("result transfer with no decoded frame pending: 0x%0h", m_tdata);
                mismatches++;
            end else begin
                want = decoded_queue.pop_front();
                if (want.crc_ok) begin
                    good_frames++;
                end else begin
                    bad_frames++;
                end
                check_field("crc_ok",          32'(want.crc_ok),  32'(m_tdata[0]));
                check_field("battery_level",   32'(want.battery), 32'(m_tdata[8:1]));
                check_field("speed_left",      32'(want.speed_l), 32'(m_tdata[22:9]));
                check_field("speed_right",     32'(want.speed_r), 32'(m_tdata[36:23]));
                check_field("ir_left",         32'(want.ir_l),    32'(m_tdata[44:37]));
                check_field("ir_right",        32'(want.ir_r),    32'(m_tdata[52:45]));
                check_field("ir_left_second",  32'(want.ir_l2),   32'(m_tdata[60:53]));
                check_field("ir_right_second", 32'(want.ir_r2),   32'(m_tdata[68:61]));
                check_field("odometer_left",   want.odo_l,        m_tdata[100:69]);
                check_field("odometer_right",  want.odo_r,        m_tdata[132:101]);
                check_field("zero fill",       32'(want.fill),    32'(m_tdata[135:133]));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("FAIL sensor_frame_crc_decoder");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] data, input logic start);
        frame_byte_t fb;
        fb.data  = data;
        fb.start = start;
        byte_queue.push_back(fb);
    endtask

    // Sends bytes 0..18 of a body plus its CRC; a corrupt frame has one bit flipped
    // either in the CRC trailer or in a covered byte after the CRC was taken.
    task automatic push_frame(input logic [7:0] body[19], input bit corrupt);
        logic [15:0] crc;
        logic [7:0]  sent[19];
        crc  = CRC_INIT;
        sent = body;
        for (int i = 0; i < CRC_LEN; i++) begin
            crc = crc16_update(crc, body[i]);
        end
        if (corrupt) begin
            if ($urandom_range(1)) begin
                crc = crc ^ (16'h0001 << $urandom_range(15));
            end else begin
                sent[5'($urandom_range(CRC_LEN - 1))] ^= 8'h01 << $urandom_range(7);
            end
        end
        for (int i = 0; i < 19; i++) begin
            push_byte(sent[i], i == 0);
        end
        push_byte(crc[7:0], 1'b0);
        push_byte(crc[15:8], 1'b0);
    endtask

    initial begin : stimulus
        logic [7:0]  body[19];
        logic [15:0] speed_pick[6];
        int          frame_items;
        int          kind;
        int          n;

        speed_pick = '{16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000, 16'hFFFB, 16'h0005};

        // Bytes while idle, a frame abandoned by a restart, then a frame of extremes.
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hA5, 1'b1);
        push_byte(8'h5A, 1'b0);
        push_byte(8'h3C, 1'b0);
        body = '{8'h00, 8'h80, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h80, 8'hFF,
                 8'h7F, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'hAA, 8'h55};
        push_frame(body, 1'b0);
        frame_items = 24;

        while (frame_items < STIM_BYTES) begin
            kind = $urandom_range(99);
            if (kind < 10) begin
                // Stray bytes without a frame start; the decoder drops them while idle.
                n = $urandom_range(1, 5);
                repeat (n) push_byte(8'($urandom_range(255)), 1'b0);
            end else if (kind < 22) begin
                // Partial frame that the next frame start abandons.
                n = $urandom_range(1, FRAME_BYTES - 1);
                for (int i = 0; i < n; i++) begin
                    push_byte(8'($urandom_range(255)), i == 0);
                end
                frame_items += n;
            end else begin
                foreach (body[i]) body[i] = 8'($urandom_range(255));
                if ($urandom_range(3) == 0) begin
                    {body[POS_SPEED_L_HI], body[POS_SPEED_L_LO]} =
                        speed_pick[3'($urandom_range(5))];
                    {body[POS_SPEED_R_HI], body[POS_SPEED_R_LO]} =
                        speed_pick[3'($urandom_range(5))];
                end
                push_frame(body, kind >= 85);
                frame_items += FRAME_BYTES;
            end
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (byte_queue.size() != 0 || s_tvalid) @(posedge aclk);
        while (decoded_queue.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d byte transfers under varying source and sink stalls, with a %0d-cycle",
                 bytes_taken, HOLD_CYCLES);
        $display("output stall; checked %0d frames with good CRC and %0d with bad CRC.",
                 good_frames, bad_frames);
        if (mismatches == 0 && decoded_queue.size() == 0) begin
            $display("PASS sensor_frame_crc_decoder");
        end else begin
            $display("FAIL sensor_frame_crc_decoder");
        end
        $finish;
    end

endmodule
